// ===== rtl/button_bank_select_controller_defines.svh =====
// Assertion macros shared by the bank select controller RTL.
`ifndef BUTTON_BANK_SELECT_CONTROLLER_DEFINES_SVH
`define BUTTON_BANK_SELECT_CONTROLLER_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define BBSC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define BBSC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/bbsc_pkg.sv =====
// Types and constants for the bank select controller.
package bbsc_pkg;

    localparam int unsigned TICK_W   = 5;
    localparam int unsigned BANK_W   = 2;
    localparam int unsigned CFG_IDX_W = 1;
    localparam int unsigned CFG_DAT_W = 1;

    // Hold and release thresholds in ticks (exceeded, not reached)
    localparam logic [TICK_W-1:0] LONG_PRESS_TICKS = 5'd15;
    localparam logic [TICK_W-1:0] RELEASE_TICKS    = 5'd30;

    // Bank index masks for two and four banks
    localparam logic [BANK_W-1:0] MASK_TWO_BANKS  = 2'd1;
    localparam logic [BANK_W-1:0] MASK_FOUR_BANKS = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FOUR_BANKS   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_LED_INVERTED = 1'b1;

    typedef struct packed {
        logic four_banks;
        logic led_inverted;
    } t_cfg;

    typedef struct packed {
        logic              select_mode;
        logic [TICK_W-1:0] tick_count;
        logic              released_seen;
        logic              skip_reset;
        logic [BANK_W-1:0] bank_index;
        logic [BANK_W-1:0] saved_bank;
    } t_state;

    typedef struct packed {
        logic [BANK_W-1:0] bank_select;
        logic              led_on;
        logic              reset_pulse;
        logic              save_strobe;
    } t_result;

endpackage

// ===== rtl/bbsc_step.sv =====
// Next-state and result logic for one polling tick.
module bbsc_step import bbsc_pkg::*; (
    input  t_cfg    i_cfg,
    input  t_state  i_state,
    input  logic    i_long_key,
    input  logic    i_reset_key,
    output t_state  o_state,
    output t_result o_result
);

    logic              both_released;
    logic [BANK_W-1:0] mask;
    logic [TICK_W-1:0] tick_inc;
    logic              pulse;
    logic              save;

    assign both_released = !i_long_key && !i_reset_key;
    assign mask          = i_cfg.four_banks ? MASK_FOUR_BANKS : MASK_TWO_BANKS;
    assign tick_inc      = i_state.tick_count + 5'd1;

    // Mode handling: idle hold detection, select-mode advance and release timeout
    always_comb begin
        o_state = i_state;
        pulse   = 1'b0;
        save    = 1'b0;
        if (!i_state.select_mode) begin
            o_state.tick_count = i_long_key ? tick_inc : '0;
            if (o_state.tick_count > LONG_PRESS_TICKS || i_reset_key) begin
                o_state.select_mode   = 1'b1;
                o_state.released_seen = 1'b0;
                o_state.tick_count    = '0;
                o_state.skip_reset    = i_reset_key;
            end
        end else begin
            priority if (!i_state.released_seen && both_released) begin
                // first release only arms the advance
                o_state.released_seen = 1'b1;
            end else if (i_state.released_seen && !both_released) begin
                o_state.released_seen = 1'b0;
                o_state.skip_reset    = 1'b0;
                o_state.bank_index    = (i_state.bank_index + 2'd1) & mask;
            end else if (both_released) begin
                o_state.tick_count = tick_inc;
                if (tick_inc > RELEASE_TICKS) begin
                    o_state.released_seen = 1'b1;
                    pulse                 = !i_state.skip_reset;
                    if (i_state.bank_index != i_state.saved_bank) begin
                        save               = 1'b1;
                        o_state.saved_bank = i_state.bank_index;
                    end
                    o_state.tick_count  = '0;
                    o_state.select_mode = 1'b0;
                end
            end else begin
                o_state.tick_count = '0;
            end
        end
    end

    // LED follows the state before this tick
    assign o_result.led_on = ((i_state.bank_index != '0) && i_cfg.led_inverted)
                             ^ !i_state.tick_count[1];
    assign o_result.bank_select = o_state.bank_index;
    assign o_result.reset_pulse = pulse;
    assign o_result.save_strobe = save;

endmodule

// ===== rtl/button_bank_select_controller.sv =====
// Bank select controller: two-button bank selection driven by polling ticks.
// State update and result are one pass of logic; the result is then registered.
// Throughput: one request per cycle while the output register is free or taken.
// The output register frees as it is taken, so requests flow back to back.
// Reset (synchronous, active low) returns to idle, bank 0, both registers 0.
`include "button_bank_select_controller_defines.svh"
module button_bank_select_controller import bbsc_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration writes
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_DAT_W-1:0] i_cfg_data,
    // tick requests
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic                 i_long_key_pressed,
    input  logic                 i_reset_key_pressed,
    // results
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [BANK_W-1:0]    o_bank_select,
    output logic                 o_led_on,
    output logic                 o_reset_pulse,
    output logic                 o_save_strobe
);

    t_cfg    r_cfg;
    t_state  r_state;
    t_state  n_state;
    t_result r_out;
    t_result n_out;
    logic    r_out_valid;
    logic    in_accept;

    // Accept whenever the result register is empty or being drained
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_accept  = i_in_valid && o_in_ready;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_FOUR_BANKS:   r_cfg.four_banks   <= i_cfg_data[0];
                CFG_LED_INVERTED: r_cfg.led_inverted <= i_cfg_data[0];
                default:          r_cfg <= r_cfg;
            endcase
        end
    end

    bbsc_step u_step (
        .i_cfg       (r_cfg),
        .i_state     (r_state),
        .i_long_key  (i_long_key_pressed),
        .i_reset_key (i_reset_key_pressed),
        .o_state     (n_state),
        .o_result    (n_out)
    );

    // Controller state advances once per accepted request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (in_accept) begin
            r_state <= n_state;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_bank_select = r_out.bank_select;
    assign o_led_on      = r_out.led_on;
    assign o_reset_pulse = r_out.reset_pulse;
    assign o_save_strobe = r_out.save_strobe;

    // Checks
    `BBSC_ASSERT_NOW(a_save_matches_bank, i_clk, i_rst_n, r_out_valid && r_out.save_strobe, r_state.saved_bank == r_out.bank_select, "save strobe without saved bank update")
    `BBSC_ASSERT_NOW(a_idle_tick_bound, i_clk, i_rst_n, !r_state.select_mode, r_state.tick_count <= LONG_PRESS_TICKS, "idle hold counter past threshold")
    `BBSC_ASSERT_NOW(a_exit_to_idle, i_clk, i_rst_n, r_out_valid && (r_out.reset_pulse || r_out.save_strobe), !r_state.select_mode, "exit strobe while still in select mode")
    `BBSC_ASSERT_NEXT(a_state_holds, i_clk, i_rst_n, !in_accept, $stable(r_state), "state changed without a request")

endmodule

// ===== test/testbench.sv =====
// Testbench for the button bank select controller: tick stimulus, prediction and result checks.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import bbsc_pkg::*;

    localparam int NUM_PHASES      = 8;
    localparam int TICKS_PER_PHASE = 250;
    localparam int MAX_IDLE        = 14;
    localparam int HOLD_CYCLES     = 120;
    localparam int STALL_LIMIT     = 4000;

    // Predicts each tick's result and checks the block's results in order
    class bank_select_scoreboard;
        localparam int REPORT_LIMIT = 10;

        t_cfg    cfg;
        t_state  st;
        t_result expected_q[$];
        int      mismatches;
        int      checked;
        int      hold_entries;
        int      reset_entries;
        int      bank_steps;
        int      exits;
        int      pulses;
        int      saves;

        function new();
            cfg = '0;
            st  = '0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // Advance the predicted state by one accepted tick request
        function void note_tick(logic long_key, logic reset_key);
            t_result           res;
            logic              both_up;
            logic [BANK_W-1:0] mask;
            both_up = !long_key && !reset_key;
            mask    = cfg.four_banks ? MASK_FOUR_BANKS : MASK_TWO_BANKS;
            res     = '0;
            // LED uses the state from before this tick
            res.led_on = ((st.bank_index != '0) && cfg.led_inverted) ^ !st.tick_count[1];

            if (!st.select_mode) begin
                st.tick_count = long_key ? st.tick_count + 5'd1 : '0;
                if (st.tick_count > LONG_PRESS_TICKS || reset_key) begin
                    if (reset_key) reset_entries++;
                    else hold_entries++;
                    st.select_mode   = 1'b1;
                    st.released_seen = 1'b0;
                    st.tick_count    = '0;
                    st.skip_reset    = reset_key;
                end
            end else if (!st.released_seen && both_up) begin
                // first release only arms the next press
                st.released_seen = 1'b1;
            end else if (st.released_seen && !both_up) begin
                st.released_seen = 1'b0;
                st.skip_reset    = 1'b0;
                st.bank_index    = (st.bank_index + 2'd1) & mask;
                bank_steps++;
            end else if (both_up) begin
                st.tick_count = st.tick_count + 5'd1;
                if (st.tick_count > RELEASE_TICKS) begin
                    st.released_seen = 1'b1;
                    res.reset_pulse  = !st.skip_reset;
                    if (st.bank_index != st.saved_bank) begin
                        res.save_strobe = 1'b1;
                        st.saved_bank   = st.bank_index;
                    end
                    st.tick_count  = '0;
                    st.select_mode = 1'b0;
                    exits++;
                    pulses += int'(res.reset_pulse);
                    saves  += int'(res.save_strobe);
                end
            end else begin
                st.tick_count = '0;
            end

            res.bank_select = st.bank_index;
            expected_q.push_back(res);
        endfunction

        // Compare one accepted result with the oldest prediction
        function void check_result(t_result got);
            t_result exp;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("error: result with nothing pending: bank %0d led %b rst %b save %b",
                             got.bank_select, got.led_on, got.reset_pulse, got.save_strobe);
                return;
            end
            exp = expected_q.pop_front();
            checked++;
            if (got.bank_select !== exp.bank_select || got.led_on !== exp.led_on ||
                got.reset_pulse !== exp.reset_pulse || got.save_strobe !== exp.save_strobe) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("error: result %0d expected bank %0d led %b rst %b save %b,",
                             checked, exp.bank_select, exp.led_on, exp.reset_pulse,
                             exp.save_strobe,
                             " got bank %0d led %b rst %b save %b",
                             got.bank_select, got.led_on, got.reset_pulse,
                             got.save_strobe);
            end
        endfunction

        function void count_leftover();
            if (expected_q.size() != 0) begin
                $display("error: %0d results never arrived", expected_q.size());
                mismatches += expected_q.size();
            end
        endfunction
    endclass

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [CFG_DAT_W-1:0] i_cfg_data = '0;
    logic              i_in_valid = 1'b0;
    logic              o_in_ready;
    logic              i_long_key_pressed = 1'b0;
    logic              i_reset_key_pressed = 1'b0;
    logic              o_out_valid;
    logic              i_out_ready = 1'b0;
    logic [BANK_W-1:0] o_bank_select;
    logic              o_led_on;
    logic              o_reset_pulse;
    logic              o_save_strobe;

    bank_select_scoreboard sb = new();
    bit tx_idle_on;
    bit rx_idle_on;
    bit hold_req;
    int ticks_sent;
    int config_count;
    int stall_cycles;

    button_bank_select_controller DUT (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_idx          (i_cfg_idx),
        .i_cfg_data         (i_cfg_data),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_long_key_pressed (i_long_key_pressed),
        .i_reset_key_pressed(i_reset_key_pressed),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_bank_select      (o_bank_select),
        .o_led_on           (o_led_on),
        .o_reset_pulse      (o_reset_pulse),
        .o_save_strobe      (o_save_strobe)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Handshake monitor: results are checked before the same edge's request is noted
    always @(posedge i_clk) begin
        t_result got;
        bit      moved;
        moved = 1'b0;
        if (i_rst_n) begin
            if (o_out_valid === 1'b1 && i_out_ready) begin
                got.bank_select = o_bank_select;
                got.led_on      = o_led_on;
                got.reset_pulse = o_reset_pulse;
                got.save_strobe = o_save_strobe;
                sb.check_result(got);
                moved = 1'b1;
            end
            if (i_in_valid && o_in_ready === 1'b1) begin
                sb.note_tick(i_long_key_pressed, i_reset_key_pressed);
                moved = 1'b1;
            end
        end
        stall_cycles = moved ? 0 : stall_cycles + 1;
    end

    // Watchdog on cycles without any handshake
    initial begin
        while (stall_cycles < STALL_LIMIT) @(posedge i_clk);
        $display("error: no handshake for %0d cycles", STALL_LIMIT);
        $display("tb: failure");
        $finish;
    end

    // Result side: random stalls, plus one long hold-off on request
    initial begin
        int wait_cycles;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                wait_cycles = HOLD_CYCLES;
                hold_req    = 1'b0;
            end else begin
                wait_cycles = rx_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
            end
            if (wait_cycles > 0) begin
                i_out_ready <= 1'b0;
                repeat (wait_cycles) @(negedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (o_out_valid !== 1'b1);
        end
    end

    // Offer one tick request; starts and ends at a falling edge
    task automatic send_tick(input logic long_key, input logic reset_key);
        int gap;
        gap = tx_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid          <= 1'b1;
        i_long_key_pressed  <= long_key;
        i_reset_key_pressed <= reset_key;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        @(negedge i_clk);
        ticks_sent++;
    endtask

    task automatic press_keys(input int n);
        logic [1:0] combo;
        repeat (n) begin
            combo = 2'($urandom_range(1, 3));
            send_tick(combo[1], combo[0]);
        end
    endtask

    task automatic release_keys(input int n);
        repeat (n) send_tick(1'b0, 1'b0);
    endtask

    // Stop offering and wait until every predicted result has come back
    task automatic drain_results();
        i_in_valid <= 1'b0;
        @(negedge i_clk);
        while (sb.pending() != 0) @(negedge i_clk);
    endtask

    // Write both registers back to back while the block is idle
    task automatic set_config(input logic four, input logic led_inv);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_FOUR_BANKS;
        i_cfg_data <= four;
        @(negedge i_clk);
        i_cfg_idx  <= CFG_LED_INVERTED;
        i_cfg_data <= led_inv;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        sb.cfg.four_banks   = four;
        sb.cfg.led_inverted = led_inv;
        config_count++;
    endtask

    // One user interaction: mostly entry, presses and release timeout; some noise
    task automatic run_session();
        int kind;
        kind = $urandom_range(0, 9);
        if (kind == 0) begin
            repeat ($urandom_range(5, 20))
                send_tick($urandom_range(0, 1) != 0, $urandom_range(0, 1) != 0);
        end else if (kind == 1) begin
            // hold that stops at or below the long-press threshold
            repeat ($urandom_range(1, 15)) send_tick(1'b1, 1'b0);
            release_keys($urandom_range(1, 3));
        end else begin
            if ($urandom_range(0, 1) != 0) begin
                repeat (16) send_tick(1'b1, 1'b0);
                press_keys($urandom_range(0, 3));
            end else begin
                send_tick($urandom_range(0, 1) != 0, 1'b1);
                press_keys($urandom_range(0, 2));
            end
            repeat ($urandom_range(0, 5)) begin
                // now and then a release right around the timeout
                if ($urandom_range(0, 7) == 0) release_keys($urandom_range(25, 32));
                else release_keys($urandom_range(1, 12));
                press_keys($urandom_range(1, 3));
            end
            // usually time out; sometimes stay in select mode
            if ($urandom_range(0, 4) != 0) release_keys($urandom_range(32, 34));
            else release_keys($urandom_range(10, 31));
        end
    endtask

    initial begin
        int phase;
        int base;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: every key combination in select mode, three of them in idle, two banks, default LED
        send_tick(1'b0, 1'b0);  // idle, nothing held
        send_tick(1'b1, 1'b0);  // hold starts counting
        send_tick(1'b0, 1'b0);  // release clears the hold count
        send_tick(1'b0, 1'b1);  // reset key enters select, pulse skipped
        send_tick(1'b1, 1'b1);  // still held: timer cleared
        send_tick(1'b0, 1'b0);  // first release is only recorded
        send_tick(1'b0, 1'b0);  // release timer counts
        send_tick(1'b1, 1'b0);  // new press: bank 0 -> 1
        send_tick(1'b0, 1'b0);
        send_tick(1'b0, 1'b1);  // reset key also steps: wraps to 0
        send_tick(1'b0, 1'b0);
        send_tick(1'b1, 1'b1);  // step to 1
        send_tick(1'b1, 1'b0);  // held: no step
        drain_results();

        // Random phases, each under its own register setting
        for (phase = 0; phase < NUM_PHASES; phase++) begin
            unique case (phase)
                0: set_config(1'b1, 1'b1);
                1: set_config(1'b0, 1'b0);
                2: set_config(1'b1, 1'b0);
                3: set_config(1'b0, 1'b1);
                default: set_config($urandom_range(0, 1) != 0, $urandom_range(0, 1) != 0);
            endcase
            tx_idle_on = (phase == 1 || phase == 2) ? 1'b0 : ($urandom_range(0, 3) != 0);
            rx_idle_on = (phase == 1) ? 1'b0 : ($urandom_range(0, 3) != 0);
            // back-pressure: result side holds off while requests keep coming
            if (phase == 2) hold_req = 1'b1;
            base = ticks_sent;
            while (ticks_sent - base < TICKS_PER_PHASE) begin
                run_session();
                // sender pauses mid-phase until everything has drained
                if (phase == 4 && $urandom_range(0, 3) == 0) drain_results();
            end
            drain_results();
        end

        repeat (8) @(negedge i_clk);
        sb.count_leftover();
        $display("summary: %0d tick requests, %0d results checked, %0d register settings",
                 ticks_sent, sb.checked, config_count);
        $display("summary: select entered %0d by hold, %0d by reset key;",
                 sb.hold_entries, sb.reset_entries,
                 " %0d bank steps, %0d timeouts, %0d reset pulses, %0d saves",
                 sb.bank_steps, sb.exits, sb.pulses, sb.saves);
        if (sb.mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule

// ===== sim.f =====
+incdir+rtl
rtl/bbsc_pkg.sv
rtl/bbsc_step.sv
rtl/button_bank_select_controller.sv
test/testbench.sv
